@@ sv/optical_flow_rate_filter_defines.svh @@
// assertion macros shared by the checker
`ifndef OPTICAL_FLOW_RATE_FILTER_DEFINES_SVH
`define OPTICAL_FLOW_RATE_FILTER_DEFINES_SVH

// implication checked on the next clock edge
`define OFRF_ASSERT_NEXT(label, cond, expect_expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (expect_expr)) else $error(msg);

// condition that holds on every clock edge
`define OFRF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond)) else $error(msg);

`endif

@@ sv/ofrf_pkg.sv @@
// types, constants and register codes of the optical flow rate filter
package ofrf_pkg;

	localparam int RATE_FRAC_BITS_DEF = 16;
	localparam int AGE_WIDTH_DEF      = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_PER_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUALITY_FLOOR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_WINDOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAU_X          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAU_Y          = 3'd4;

	localparam logic [23:0] RATE_PER_COUNT_RST = 24'd34393;
	localparam logic [7:0]  QUALITY_FLOOR_RST  = 8'd19;
	localparam logic [15:0] STALE_WINDOW_RST   = 16'd50;

	localparam logic [23:0] ELAPSED_LO = 24'd100;
	localparam logic [23:0] ELAPSED_HI = 24'd500000;

	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [16:0] Q16_ONE      = 17'd65536;
	localparam logic [16:0] LOG2E_Q16    = 17'd94548;
	localparam logic [4:0]  EXP_SHIFT_MAX = 5'd17;
	localparam logic [15:0] HORNER_C0 = 16'd630;
	localparam logic [15:0] HORNER_C1 = 16'd3638;
	localparam logic [15:0] HORNER_C2 = 16'd15744;
	localparam logic [15:0] HORNER_C3 = 16'd45426;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 40;

	localparam int FIFO_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_SAMPLE,
		KIND_REJECT
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [7:0]         quality;
		logic [23:0]        elapsed_us;
	} cmd_t;

	typedef struct packed {
		logic [23:0] rate_per_count_q24;
		logic [7:0]  quality_floor;
		logic [15:0] stale_window_ms;
		logic [23:0] tau_x_us;
		logic [23:0] tau_y_us;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MAG,
		ST_MHI,
		ST_MLO,
		ST_RDIV,
		ST_RWAIT,
		ST_RSAT,
		ST_GDIV,
		ST_GWAIT,
		ST_GLOG,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_KCALC,
		ST_UMUL,
		ST_UPD,
		ST_COMMIT,
		ST_OUT
	} state_t;

endpackage

@@ sv/optical_flow_rate_filter.sv @@
// Optical flow rate filter, top level.
// Input stream s_*: one item per motion sample or per one-millisecond tick;
// tuser bit 0 selects a tick, bit 1 flags a good sensor read.
// Output stream m_*: exactly one result per input item, in order: filtered
// x and y rates in signed fixed point, the kept quality and a valid flag.
// Registers are written through cfg_we / cfg_index / cfg_data while idle.
// A two-entry command queue separates input decode from execution, so the
// input keeps taking items while the execution side is busy or stalled.
// A good sample runs, per axis, two 64-step divisions on the shared
// restoring divider (rate and low-pass exponent) plus the multiplies and
// gain polynomial; an axis with tau zero skips the exponent division.
// Ticks and rejected samples skip all of it. The execution side takes a
// new item only after its last result has gone into the output register.
// Reset clears the filter, marks it unseeded and sets the age to stale;
// the register file returns to its default values.
// When m_tready is low the result holds in the output register, the next
// item waits finished in the execution side and the queue fills, after
// which s_tready drops.
module optical_flow_rate_filter import ofrf_pkg::*; #(
	parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF,
	parameter int AGE_WIDTH      = AGE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// delta_x, delta_y, quality, elapsed_us
	input  logic [63:0]           s_tdata,
	// func, read_ok
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// rate_x, rate_y, last_quality
	output logic [71:0]           m_tdata,
	// flow_valid
	output logic [0:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	cmd_t q_in;
	logic q_pop;
	logic q_empty;
	cmd_t q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_per_count_q24 <= RATE_PER_COUNT_RST;
			cfg_q.quality_floor      <= QUALITY_FLOOR_RST;
			cfg_q.stale_window_ms    <= STALE_WINDOW_RST;
			cfg_q.tau_x_us           <= '0;
			cfg_q.tau_y_us           <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE_PER_COUNT: cfg_q.rate_per_count_q24 <= cfg_data;
				REG_QUALITY_FLOOR:  cfg_q.quality_floor      <= cfg_data[7:0];
				REG_STALE_WINDOW:   cfg_q.stale_window_ms    <= cfg_data[15:0];
				REG_TAU_X:          cfg_q.tau_x_us           <= cfg_data;
				REG_TAU_Y:          cfg_q.tau_y_us           <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ofrf_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_in)
	);

	ofrf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (q_out)
	);

	ofrf_back #(
		.RATE_FRAC_BITS (RATE_FRAC_BITS),
		.AGE_WIDTH      (AGE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_cmd    (q_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ sv/ofrf_front.sv @@
// input side: takes items and sorts them into tick, sample or reject
module ofrf_front import ofrf_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic [23:0] elapsed;
	logic        in_window;

	assign elapsed   = s_tdata[63:40];
	assign in_window = (elapsed > ELAPSED_LO) && (elapsed < ELAPSED_HI);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd.delta_x    = s_tdata[15:0];
		q_cmd.delta_y    = s_tdata[31:16];
		q_cmd.quality    = s_tdata[39:32];
		q_cmd.elapsed_us = elapsed;
		if (s_tuser[0]) begin
			q_cmd.kind = KIND_TICK;
		end else if (s_tuser[1] && in_window) begin
			q_cmd.kind = KIND_SAMPLE;
		end else begin
			q_cmd.kind = KIND_REJECT;
		end
	end

endmodule

@@ sv/ofrf_fifo.sv @@
// short command queue between the input side and the execution side
module ofrf_fifo import ofrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/ofrf_div.sv @@
// restoring divider, one quotient bit per cycle
module ofrf_div import ofrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic                 busy,
	output logic [DIV_NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial    = {rem_q, quot_q[DIV_NUM_W-1]};
	assign fits     = (trial >= {1'b0, den_q});
	assign busy     = busy_q;
	assign quotient = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quot_q <= {quot_q[DIV_NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/ofrf_back.sv @@
// execution side: rate conversion, low-pass gain, filter update and result register
module ofrf_back import ofrf_pkg::*; #(
	parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF,
	parameter int AGE_WIDTH      = AGE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic [0:0]  m_tuser
);

	localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

	state_t state_q, state_d;

	cmd_t                 cmd_q;
	logic                 ax_q;
	logic [39:0]          prod_q;
	logic [39:0]          nh_q;
	logic [63:0]          num_q;
	logic signed [31:0]   raw_q;
	logic                 big_q;
	logic [4:0]           i_q;
	logic [15:0]          g_q;
	logic [15:0]          t_q;
	logic [16:0]          k_q;
	logic signed [50:0]   upd_q;
	logic signed [31:0]   filt_x_q;
	logic signed [31:0]   filt_y_q;
	logic                 seeded_q;
	logic [7:0]           kept_quality_q;
	logic                 quality_ok_q;
	logic [AGE_WIDTH-1:0] age_q;
	logic                 out_valid_q;
	logic [71:0]          out_data_q;
	logic                 out_user_q;

	logic                 div_start;
	logic [63:0]          div_num;
	logic [39:0]          div_den;
	logic                 div_busy;
	logic [63:0]          div_quot;

	logic signed [15:0]   cnt;
	logic [16:0]          mag;
	logic                 neg;
	logic [39:0]          den;
	logic [23:0]          tau;
	logic signed [31:0]   f_cur;
	logic signed [32:0]   diff;
	logic signed [50:0]   upd_adj;
	logic signed [32:0]   new_sum;
	logic [36:0]          v_full;
	logic [31:0]          sat_rate;
	logic [16:0]          p_shift;
	logic                 out_free;
	logic                 flow_valid;

	ofrf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// per-axis count: x is the negated sensor delta
	assign cnt = ax_q ? cmd_q.delta_y : cmd_q.delta_x;
	assign mag = cnt[15] ? 17'(17'd0 - {cnt[15], cnt}) : {1'b0, cnt};
	assign neg = ax_q ? cmd_q.delta_y[15] : (!cmd_q.delta_x[15] && (cmd_q.delta_x != '0));
	assign den = 40'({16'd0, cmd_q.elapsed_us} << (24 - RATE_FRAC_BITS));
	assign tau = ax_q ? cfg.tau_y_us : cfg.tau_x_us;

	always_comb begin
		if (neg) begin
			if ((|div_quot[63:32]) || (div_quot[31] && (|div_quot[30:0]))) begin
				sat_rate = 32'h8000_0000;
			end else begin
				sat_rate = 32'd0 - div_quot[31:0];
			end
		end else begin
			sat_rate = (|div_quot[63:31]) ? 32'h7fff_ffff : div_quot[31:0];
		end
	end

	assign v_full = div_quot[19:0] * LOG2E_Q16;

	// an unseeded filter starts at the raw rate, so the step is zero
	assign f_cur   = seeded_q ? (ax_q ? filt_y_q : filt_x_q) : raw_q;
	assign diff    = 33'(raw_q) - 33'(f_cur);
	assign upd_adj = upd_q + (upd_q[50] ? 51'sd65535 : 51'sd0);
	assign new_sum = 33'(f_cur) + upd_adj[48:16];
	assign p_shift = 17'(Q16_ONE - {1'b0, t_q}) >> i_q;

	assign out_free   = !out_valid_q || m_tready;
	assign flow_valid = quality_ok_q && seeded_q && (age_q != AGE_MAX) &&
		(CMP_W'(age_q) < CMP_W'(cfg.stale_window_ms));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_d = (q_cmd.kind == KIND_SAMPLE) ? ST_MAG : ST_OUT;
				end
			end
			ST_MAG:   state_d = ST_MHI;
			ST_MHI:   state_d = ST_MLO;
			ST_MLO:   state_d = ST_RDIV;
			ST_RDIV:  state_d = ST_RWAIT;
			ST_RWAIT: state_d = div_busy ? ST_RWAIT : ST_RSAT;
			ST_RSAT:  state_d = ST_GDIV;
			ST_GDIV:  state_d = (tau == '0) ? ST_KCALC : ST_GWAIT;
			ST_GWAIT: state_d = div_busy ? ST_GWAIT : ST_GLOG;
			ST_GLOG:  state_d = ST_H0;
			ST_H0:    state_d = ST_H1;
			ST_H1:    state_d = ST_H2;
			ST_H2:    state_d = ST_H3;
			ST_H3:    state_d = ST_KCALC;
			ST_KCALC: state_d = ST_UMUL;
			ST_UMUL:  state_d = ST_UPD;
			ST_UPD:   state_d = ax_q ? ST_COMMIT : ST_MAG;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT:   state_d = out_free ? ST_IDLE : ST_OUT;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = num_q;
		div_den   = den;
		unique case (state_q)
			ST_IDLE: q_pop = !q_empty;
			ST_RDIV: div_start = 1'b1;
			ST_GDIV: begin
				div_start = (tau != '0);
				div_num   = {24'd0, cmd_q.elapsed_us, 16'd0};
				div_den   = {16'd0, tau};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= q_cmd;
			end
			ST_MAG: prod_q <= 40'(mag * cfg.rate_per_count_q24);
			ST_MHI: nh_q   <= prod_q[39:20] * USEC_PER_SEC;
			ST_MLO: num_q  <= {4'd0, nh_q, 20'd0} + 64'(prod_q[19:0] * USEC_PER_SEC);
			ST_RSAT: raw_q <= sat_rate;
			ST_GDIV: big_q <= (tau == '0);
			ST_GLOG: begin
				big_q <= |div_quot[63:20];
				i_q   <= v_full[36:32];
				g_q   <= v_full[31:16];
			end
			ST_H0: t_q <= HORNER_C1 - 16'((32'(HORNER_C0) * g_q) >> 16);
			ST_H1: t_q <= HORNER_C2 - 16'((32'(t_q) * g_q) >> 16);
			ST_H2: t_q <= HORNER_C3 - 16'((32'(t_q) * g_q) >> 16);
			ST_H3: t_q <= 16'((32'(t_q) * g_q) >> 16);
			ST_KCALC: begin
				if (big_q || (i_q >= EXP_SHIFT_MAX)) begin
					k_q <= Q16_ONE;
				end else begin
					k_q <= Q16_ONE - p_shift;
				end
			end
			ST_UMUL: upd_q <= 51'(diff * $signed({1'b0, k_q}));
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= {kept_quality_q, filt_y_q, filt_x_q};
			out_user_q <= flow_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ax_q           <= 1'b0;
			filt_x_q       <= '0;
			filt_y_q       <= '0;
			seeded_q       <= 1'b0;
			kept_quality_q <= '0;
			quality_ok_q   <= 1'b0;
			age_q          <= AGE_MAX;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && !q_empty) begin
				ax_q <= 1'b0;
				if (q_cmd.kind == KIND_TICK && age_q != AGE_MAX) begin
					age_q <= age_q + 1'b1;
				end
			end
			if (state_q == ST_UPD) begin
				ax_q <= 1'b1;
				if (ax_q) begin
					filt_y_q <= new_sum[31:0];
				end else begin
					filt_x_q <= new_sum[31:0];
				end
			end
			if (state_q == ST_COMMIT) begin
				seeded_q       <= 1'b1;
				kept_quality_q <= cmd_q.quality;
				quality_ok_q   <= (cmd_q.quality >= cfg.quality_floor);
				age_q          <= '0;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ sv/ofrf_checker.sv @@
// port-level checker for the optical flow rate filter and its bind
`include "optical_flow_rate_filter_defines.svh"

module ofrf_checker import ofrf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        cfg_we
);

	logic       in_acc;
	logic       out_acc;
	logic [3:0] pend_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// items taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`OFRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`OFRF_ASSERT_ALWAYS(a_no_invented, !m_tvalid || (pend_q != 4'd0), "result without a pending item")
	`OFRF_ASSERT_ALWAYS(a_bounded, pend_q <= 4'd4, "more items in flight than storage")
	`OFRF_ASSERT_NEXT(a_fill_stall, pend_q == 4'd4, !s_tready, "input taken with all storage full")
	`OFRF_ASSERT_ALWAYS(a_cfg_idle, !cfg_we || (pend_q == 4'd0), "register written with items in flight")

endmodule

bind optical_flow_rate_filter ofrf_checker u_ofrf_checker (.*);
